// ===== design/ist_pkg.sv =====
// ist_pkg: shared types and constants for the integer set table.
// Beat structs, operation and status codes, table capacity.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_MEMBER = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_DUP       = 3'd4;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       is_member;
    logic [4:0] element_count;
  } result_t;

  // per-cell control from the table controller
  typedef struct packed {
    logic live;    // cell index below the element count
    logic wr;      // insert lands in this cell
    logic remove;  // accepted remove beat
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/ist_cell.sv =====
// ist_cell: one entry of the set table.
// Compares its entry with the key, ripples the first-match flag upward and
// shifts down from its upper neighbor on remove. Uses ist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ist_cell (
  input  wire                  clk,
  input  ist_pkg::cell_ctrl_t  ctrl,
  input  wire  [31:0]          key,
  input  wire  [31:0]          up_val,
  input  wire                  seen_in,
  output logic                 seen_out,
  output logic [31:0]          val
);

  logic hit;

  assign hit      = ctrl.live && (val == key);
  assign seen_out = seen_in | hit;

  // at or above the first match: close the gap
  always_ff @(posedge clk) begin
    if (ctrl.remove && seen_out) begin
      val <= up_val;
    end else if (ctrl.wr) begin
      val <= key;
    end
  end

endmodule

`default_nettype wire

// ===== design/integer_set_table.sv =====
// integer_set_table: top level, controller plus a chain of ist_cell entries.
// Depends on ist_pkg and ist_cell.
//
//   channel   beat      handshake             fields
//   command   cmd       start & !busy         func, value
//   result    result    strobe (one cycle)    status, is_member, element_count
//
// One command per clock while busy is low: compare, first-match ripple and shift
// all settle in the accept cycle across the cell chain; the result is registered and shows in the cycle after.
// busy is high only during reset and the cycle after it.
// Reset clears the element count; entry contents are left as they are.
// The receiver cannot stall; every result is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module integer_set_table (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  ist_pkg::cmd_t      cmd,
  output logic               strobe,
  output ist_pkg::result_t   result
);

  localparam int CAP = ist_pkg::CAPACITY;

  ist_pkg::cnt_t count;
  ist_pkg::cnt_t count_next;
  logic          accept;
  logic          present;
  logic          full;
  logic [2:0]    status_next;
  logic [31:0]   vals [CAP];
  logic [CAP:0]  seen;

  assign accept  = start && !busy;
  assign seen[0] = 1'b0;
  assign present = seen[CAP];
  assign full    = (count == ist_pkg::CNT_W'(CAP));

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      ist_pkg::cell_ctrl_t ctrl;
      logic [31:0]         up;

      assign ctrl.live   = ist_pkg::CNT_W'(gi) < count;
      assign ctrl.wr     = accept && (cmd.func == ist_pkg::FN_INSERT) &&
                           (count == ist_pkg::CNT_W'(gi));
      assign ctrl.remove = accept && (cmd.func == ist_pkg::FN_REMOVE);

      if (gi == CAP - 1) begin : g_top
        assign up = vals[gi];
      end else begin : g_mid
        assign up = vals[gi + 1];
      end

      ist_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .key      (cmd.value),
        .up_val   (up),
        .seen_in  (seen[gi]),
        .seen_out (seen[gi + 1]),
        .val      (vals[gi])
      );
    end
  endgenerate

  always_comb begin
    count_next  = count;
    status_next = ist_pkg::ST_OK;
    case (cmd.func)
      ist_pkg::FN_INSERT: begin
        if (present) begin
          status_next = ist_pkg::ST_DUP;
        end else if (full) begin
          status_next = ist_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ist_pkg::FN_REMOVE: begin
        if (count == '0) begin
          status_next = ist_pkg::ST_EMPTY;
        end else if (!present) begin
          status_next = ist_pkg::ST_NOT_FOUND;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ist_pkg::FN_MEMBER: begin
        status_next = present ? ist_pkg::ST_OK : ist_pkg::ST_NOT_FOUND;
      end
      default: begin
        status_next = ist_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
      busy   <= 1'b1;
    end else begin
      busy   <= 1'b0;
      strobe <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status        <= status_next;
      result.is_member     <= present;
      result.element_count <= 5'(count_next);
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> strobe) else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !strobe) else $error("result without accepted beat");

  a_dup_member: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == ist_pkg::ST_DUP) |-> result.is_member)
    else $error("duplicate reported without membership");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (32'(result.element_count) <= 32'(CAP)))
    else $error("element count beyond capacity");

endmodule

`default_nettype wire
